### rtl/core/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define STQ_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define STQ_ASSERT(lbl, clk, rstn, prop, msg)
`define STQ_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/core/stq_pkg.sv
package stq_pkg;

  localparam int TIMERS     = 32;
  localparam int TASKS      = 8;
  localparam int IDX_W      = $clog2(TIMERS);
  localparam int CNT_W      = $clog2(TIMERS + 1);
  localparam int TASK_W     = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] RECIP32 = 32'hCCCC_CCCD;
  localparam logic [15:0] RECIP16 = 16'hCCCD;

  localparam logic [1:0] REG_SWITCH_ENABLE = 2'd0;
  localparam logic [1:0] REG_SWITCH_PERIOD = 2'd1;
  localparam logic [1:0] REG_RUNNING_TASKS = 2'd2;

  localparam logic [1:0] KIND_SET_OK = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_SWITCH = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET,
    OP_CFG
  } op_e;

  typedef enum logic [1:0] {
    ORG_SET,
    ORG_CFG,
    ORG_SWITCH
  } org_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_LINK,
    ST_LINK2,
    ST_FIN,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_SW,
    ST_UNL_RD,
    ST_UNL_CHK,
    ST_END
  } back_state_e;

  // value: set -> delay in ticks; cfg -> {period ticks, raw data}
  typedef struct packed {
    op_e         op;
    logic [1:0]  idx;
    logic [7:0]  channel;
    logic [7:0]  payload;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] channel;
    logic [7:0] payload;
    logic [2:0] next_task;
  } res_t;

endpackage

### rtl/core/stq_front.sv
module stq_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  output stq_pkg::cmd_t cmd_o,
  output logic         cmd_valid_o,
  input  logic         fifo_full_i
);
  import stq_pkg::*;

  logic        st_v_q, st_v_d;
  cmd_t        st_q, st_d;
  logic        push, free;
  logic [63:0] prod32;
  logic [31:0] prod16;

  assign push          = st_v_q && !fifo_full_i;
  assign free          = !st_v_q || push;
  assign cfg_ready_o   = free;
  assign s_axis_tready = free && !cfg_valid_i;
  assign cmd_valid_o   = st_v_q;
  assign cmd_o         = st_q;

  // divide by ten through reciprocal multiplication
  assign prod32 = 64'(s_axis_tdata[47:16]) * 64'(RECIP32);
  assign prod16 = 32'(cfg_data_i) * 32'(RECIP16);

  always_comb begin
    st_d   = st_q;
    st_v_d = st_v_q;
    if (push) st_v_d = 1'b0;
    if (cfg_valid_i && free) begin
      st_v_d     = 1'b1;
      st_d.op    = OP_CFG;
      st_d.idx   = cfg_index_i;
      st_d.channel = 8'd0;
      st_d.payload = 8'd0;
      st_d.value = {16'(prod16 >> 19), cfg_data_i};
    end else if (s_axis_tvalid && s_axis_tready) begin
      st_v_d       = 1'b1;
      st_d.op      = s_axis_tuser ? OP_SET : OP_TICK;
      st_d.idx     = 2'd0;
      st_d.channel = s_axis_tdata[7:0];
      st_d.payload = s_axis_tdata[15:8];
      st_d.value   = 32'(prod32 >> 35);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= 1'b0;
    end else begin
      st_v_q <= st_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

endmodule

### rtl/core/stq_fifo.sv
module stq_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stq_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output stq_pkg::cmd_t cmd_o,
  output logic          valid_o
);
  import stq_pkg::*;

  cmd_t              mem_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FCNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

### rtl/core/stq_back.sv
`include "assert_macros.svh"

module stq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stq_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  output stq_pkg::res_t res_o,
  output logic          res_last_o,
  output logic          res_valid_o,
  input  logic          res_ready_i
);
  import stq_pkg::*;

  logic [31:0]      dl_mem   [TIMERS];
  logic [IDX_W-1:0] link_mem [TIMERS];
  logic [7:0]       ch_mem   [TIMERS];
  logic [7:0]       pl_mem   [TIMERS];

  back_state_e      state_q, state_d;
  logic [31:0]      count_q, count_d;
  logic [TIMERS-1:0] used_q, used_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] sw_slot_q, sw_slot_d;
  logic             en_q, en_d;
  logic [15:0]      pt_q, pt_d;
  logic [3:0]       rt_q, rt_d;
  logic [TASK_W-1:0] task_q, task_d;
  logic [IDX_W-1:0] cur_q, cur_d, prev_q, prev_d;
  logic             hasprev_q, hasprev_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] ins_slot_q, ins_slot_d;
  logic [31:0]      ins_dl_q, ins_dl_d;
  org_e             org_q, org_d;
  logic             do_sw_q, do_sw_d;
  logic             pend_v_q, pend_v_d;
  res_t             pend_q, pend_d;
  logic             out_v_q, out_v_d;
  res_t             out_q, out_d;
  logic             out_last_q, out_last_d;

  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_dl_q;
  logic [IDX_W-1:0] rd_link_q;
  logic [7:0]       rd_ch_q, rd_pl_q;

  logic             dl_we, link_we, chpl_we;
  logic [IDX_W-1:0] dl_wa, link_wa, chpl_wa, link_wd;
  logic [31:0]      dl_wd;
  logic [7:0]       ch_wd, pl_wd;

  logic             ff_found;
  logic [IDX_W-1:0] ff_idx;
  logic             out_free, can_add, push;
  res_t             push_res, add_res;
  logic             push_last, add_en;
  logic [7:0]       n_tasks, task_ext;
  logic             rot_reduce;
  logic [TASK_W-1:0] task_rot;

  // lowest free slot
  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int k = TIMERS - 1; k >= 0; k--) begin
      if (!used_q[k]) begin
        ff_found = 1'b1;
        ff_idx   = IDX_W'(k);
      end
    end
  end

  assign out_free = !out_v_q || res_ready_i;
  assign can_add  = !pend_v_q || out_free;
  assign n_tasks  = (8'(rt_q) > 8'(TASKS)) ? 8'(TASKS) : 8'(rt_q);
  assign task_ext = 8'(task_q);
  assign rot_reduce = (n_tasks > 8'd1) && (task_ext >= n_tasks);
  assign task_rot = (n_tasks > 8'd1) ?
                    ((task_ext + 8'd1 == n_tasks) ? '0 : task_q + 1'b1) : task_q;

  always_comb begin
    unique case (state_q)
      ST_TICK_RD, ST_TICK_CHK: rd_addr = head_q;
      default:                 rd_addr = cur_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_SET:  state_d = ff_found ? ST_WALK_RD : ST_END;
            OP_TICK: state_d = ST_TICK_RD;
            OP_CFG: begin
              if (cmd_i.idx == REG_SWITCH_ENABLE) begin
                if (cmd_i.value[0] && !en_q && ff_found) state_d = ST_WALK_RD;
                else if (!cmd_i.value[0] && en_q)        state_d = ST_UNL_RD;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_WALK_RD:  state_d = (i_q == len_q) ? ST_LINK : ST_WALK_CHK;
      ST_WALK_CHK: state_d = (ins_dl_q < rd_dl_q) ? ST_LINK : ST_WALK_RD;
      ST_LINK:     state_d = hasprev_q ? ST_LINK2 : ST_FIN;
      ST_LINK2:    state_d = ST_FIN;
      ST_FIN: begin
        if (org_q == ORG_CFG) state_d = ST_IDLE;
        else if (org_q == ORG_SWITCH && rot_reduce) state_d = ST_FIN;
        else if (can_add) state_d = ST_END;
      end
      ST_TICK_RD:  state_d = (len_q == '0) ? ST_TICK_SW : ST_TICK_CHK;
      ST_TICK_CHK: begin
        if (rd_dl_q > count_q) state_d = ST_TICK_SW;
        else if ((en_q && head_q == sw_slot_q) || can_add) state_d = ST_TICK_RD;
      end
      ST_TICK_SW:  state_d = do_sw_q ? ST_WALK_RD : ST_END;
      ST_UNL_RD:   state_d = (i_q == len_q) ? ST_IDLE : ST_UNL_CHK;
      ST_UNL_CHK:  state_d = (cur_q == sw_slot_q) ? ST_IDLE : ST_UNL_RD;
      ST_END:      if (!pend_v_q || out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d = count_q;  used_d = used_q;   head_d = head_q;   len_d = len_q;
    sw_slot_d = sw_slot_q; en_d = en_q;    pt_d = pt_q;       rt_d = rt_q;
    task_d = task_q;    cur_d = cur_q;     prev_d = prev_q;   hasprev_d = hasprev_q;
    i_d = i_q;          ins_slot_d = ins_slot_q; ins_dl_d = ins_dl_q;
    org_d = org_q;      do_sw_d = do_sw_q; pend_v_d = pend_v_q; pend_d = pend_q;
    cmd_pop_o = 1'b0;
    dl_we = 1'b0;   dl_wa = ff_idx;   dl_wd = count_q + cmd_i.value;
    link_we = 1'b0; link_wa = ins_slot_q; link_wd = cur_q;
    chpl_we = 1'b0; chpl_wa = ff_idx; ch_wd = cmd_i.channel; pl_wd = cmd_i.payload;
    push = 1'b0;    push_res = pend_q; push_last = 1'b0;
    add_en = 1'b0;  add_res = '0;

    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_SET: begin
              if (ff_found) begin
                used_d[ff_idx] = 1'b1;
                chpl_we   = 1'b1;
                dl_we     = 1'b1;
                ins_slot_d = ff_idx;
                ins_dl_d  = count_q + cmd_i.value;
                cur_d = head_q; i_d = '0; hasprev_d = 1'b0;
                org_d = ORG_SET;
              end else begin
                pend_d      = '0;
                pend_d.kind = KIND_FULL;
                pend_v_d    = 1'b1;
              end
            end
            OP_TICK: begin
              count_d = count_q + 32'd1;
              do_sw_d = 1'b0;
            end
            OP_CFG: begin
              unique case (cmd_i.idx)
                REG_SWITCH_ENABLE: begin
                  if (cmd_i.value[0] && !en_q) begin
                    if (ff_found) begin
                      sw_slot_d = ff_idx;
                      used_d[ff_idx] = 1'b1;
                      en_d  = 1'b1;
                      dl_we = 1'b1;
                      dl_wd = count_q + 32'(pt_q);
                      ins_slot_d = ff_idx;
                      ins_dl_d   = count_q + 32'(pt_q);
                      cur_d = head_q; i_d = '0; hasprev_d = 1'b0;
                      org_d = ORG_CFG;
                    end
                  end else if (!cmd_i.value[0] && en_q) begin
                    cur_d = head_q; i_d = '0;
                  end
                end
                REG_SWITCH_PERIOD: pt_d = cmd_i.value[31:16];
                REG_RUNNING_TASKS: rt_d = cmd_i.value[3:0];
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_WALK_CHK: begin
        if (!(ins_dl_q < rd_dl_q)) begin
          prev_d = cur_q; hasprev_d = 1'b1; cur_d = rd_link_q; i_d = i_q + 1'b1;
        end
      end
      ST_LINK: begin
        link_we = 1'b1;
        if (!hasprev_q) begin
          head_d = ins_slot_q;
          len_d  = len_q + 1'b1;
        end
      end
      ST_LINK2: begin
        link_we = 1'b1;
        link_wa = prev_q;
        link_wd = ins_slot_q;
        len_d   = len_q + 1'b1;
      end
      ST_FIN: begin
        if (org_q == ORG_SWITCH && rot_reduce) begin
          task_d = task_q - TASK_W'(n_tasks);
        end else if (org_q == ORG_SET && can_add) begin
          add_en = 1'b1;
          add_res.kind = KIND_SET_OK;
        end else if (org_q == ORG_SWITCH && can_add) begin
          task_d = task_rot;
          add_en = 1'b1;
          add_res.kind = KIND_SWITCH;
          add_res.next_task = 3'(task_rot);
        end
      end
      ST_TICK_CHK: begin
        if (!(rd_dl_q > count_q)) begin
          if (en_q && head_q == sw_slot_q) begin
            head_d = rd_link_q; len_d = len_q - 1'b1; do_sw_d = 1'b1;
          end else if (can_add) begin
            head_d = rd_link_q; len_d = len_q - 1'b1;
            used_d[head_q] = 1'b0;
            add_en = 1'b1;
            add_res.kind    = KIND_FIRED;
            add_res.channel = rd_ch_q;
            add_res.payload = rd_pl_q;
          end
        end
      end
      ST_TICK_SW: begin
        if (do_sw_q) begin
          ins_slot_d = sw_slot_q;
          ins_dl_d   = count_q + 32'(pt_q);
          dl_we = 1'b1; dl_wa = sw_slot_q; dl_wd = count_q + 32'(pt_q);
          cur_d = head_q; i_d = '0; hasprev_d = 1'b0;
          org_d = ORG_SWITCH;
        end
      end
      ST_UNL_RD: begin
        if (i_q == len_q) begin
          used_d[sw_slot_q] = 1'b0; en_d = 1'b0;
        end
      end
      ST_UNL_CHK: begin
        if (cur_q == sw_slot_q) begin
          if (i_q == '0) head_d = rd_link_q;
          else begin
            link_we = 1'b1; link_wa = prev_q; link_wd = rd_link_q;
          end
          len_d = len_q - 1'b1;
          used_d[sw_slot_q] = 1'b0; en_d = 1'b0;
        end else begin
          prev_d = cur_q; cur_d = rd_link_q; i_d = i_q + 1'b1;
        end
      end
      ST_END: begin
        if (pend_v_q && out_free) begin
          push = 1'b1; push_last = 1'b1; pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase

    if (add_en) begin
      if (pend_v_q) push = 1'b1;
      pend_d   = add_res;
      pend_v_d = 1'b1;
    end
  end

  always_comb begin
    out_d      = out_q;
    out_last_d = out_last_q;
    out_v_d    = out_v_q && !res_ready_i;
    if (push) begin
      out_v_d    = 1'b1;
      out_d      = push_res;
      out_last_d = push_last;
    end
  end

  assign res_o       = out_q;
  assign res_last_o  = out_last_q;
  assign res_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      used_q    <= '0;
      head_q    <= '0;
      len_q     <= '0;
      sw_slot_q <= '0;
      en_q      <= 1'b0;
      pt_q      <= 16'd2;
      rt_q      <= 4'd1;
      task_q    <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      do_sw_q   <= 1'b0;
      org_q     <= ORG_SET;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      used_q    <= used_d;
      head_q    <= head_d;
      len_q     <= len_d;
      sw_slot_q <= sw_slot_d;
      en_q      <= en_d;
      pt_q      <= pt_d;
      rt_q      <= rt_d;
      task_q    <= task_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      do_sw_q   <= do_sw_d;
      org_q     <= org_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    hasprev_q  <= hasprev_d;
    i_q        <= i_d;
    ins_slot_q <= ins_slot_d;
    ins_dl_q   <= ins_dl_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  // entry memories
  always_ff @(posedge clk_i) begin
    if (dl_we)   dl_mem[dl_wa]     <= dl_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (chpl_we) begin
      ch_mem[chpl_wa] <= ch_wd;
      pl_mem[chpl_wa] <= pl_wd;
    end
    rd_dl_q   <= dl_mem[rd_addr];
    rd_link_q <= link_mem[rd_addr];
    rd_ch_q   <= ch_mem[rd_addr];
    rd_pl_q   <= pl_mem[rd_addr];
  end

  `STQ_ASSERT(a_len_bound, clk_i, rst_ni, len_q <= CNT_W'(TIMERS), "list longer than pool")
  `STQ_ASSERT(a_idle_clean, clk_i, rst_ni, (state_q == ST_IDLE) |-> !pend_v_q, "result held at idle")
  `STQ_ASSERT(a_sw_slot_used, clk_i, rst_ni, en_q |-> used_q[sw_slot_q], "switch slot not used")
  `STQ_ASSERT(a_used_len, clk_i, rst_ni, (state_q == ST_IDLE) |-> ($countones(used_q) == int'(len_q)), "used count differs from list length")

endmodule

### rtl/core/sorted_timeout_queue_top.sv
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: channel, payload, delay_ms; tuser: mode
// cfg       in   cfg_valid_i/cfg_ready_o          cfg_index_i, cfg_data_i
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: channel, payload, next_task; tuser: kind
//
// one command at a time in the back end; the linked-list walk sets the rate
// set: a walk over the list entries passed, then the link and finish steps; tick: entries fired from the head,
// plus a re-arm walk when the switch timer fires
// front end takes the next word while the back end works, through a 2-deep queue
// no clearing pass after reset; output stalls hold the back end, and once the queue fills, the front end too
module sorted_timeout_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // channel[7:0], payload[15:8], delay_ms[47:16]
  input  logic        s_axis_tuser_i,  // mode
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // fired_channel[7:0], fired_payload[15:8], next_task[18:16]
  output logic [1:0]  m_axis_tuser_o,  // kind
  output logic        m_axis_tlast_o
);
  import stq_pkg::*;

  cmd_t front_cmd, fifo_cmd;
  logic front_v, fifo_full, fifo_v, pop;
  res_t res;

  stq_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid (s_axis_tvalid_i),
    .s_axis_tready (s_axis_tready_o),
    .s_axis_tdata  (s_axis_tdata_i),
    .s_axis_tuser  (s_axis_tuser_i),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_v),
    .fifo_full_i (fifo_full)
  );

  stq_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (front_v),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .cmd_o   (fifo_cmd),
    .valid_o (fifo_v)
  );

  stq_back u_back (
    .clk_i, .rst_ni,
    .cmd_i       (fifo_cmd),
    .cmd_valid_i (fifo_v),
    .cmd_pop_o   (pop),
    .res_o       (res),
    .res_last_o  (m_axis_tlast_o),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {5'd0, res.next_task, res.payload, res.channel};
  assign m_axis_tuser_o = res.kind;

endmodule
